[sv/rbdq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbdq_pkg: shared types and constants for the ring buffer deque
// Opcodes, sequencer states, field widths and the store control bundle.
// ----------------------------------------------------------------------------
package rbdq_pkg;

   // Default geometry of the store
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed field widths of the request and response channels
   localparam int OPCODE_WIDTH = 3;
   localparam int WORD_WIDTH   = 32;
   localparam int OCC_WIDTH    = 5;

   // Operation codes; unused codes behave as a plain read
   localparam logic [OPCODE_WIDTH-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OPCODE_WIDTH-1:0] OP_READ       = 3'd4;

   // Sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   // Store port strobes from the sequencer
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctrl_type;

endpackage

[sv/rbdq_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbdq_store: circular word store
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module rbdq_store #(
   parameter int DEPTH      = rbdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = rbdq_pkg::DATA_WIDTH_DEFAULT,
   parameter int AW         = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  rbdq_pkg::mem_ctrl_type    mem_ctrl,
   input  logic [AW-1:0]             wr_addr,
   input  logic [DATA_WIDTH-1:0]     wr_data,
   input  logic [AW-1:0]             rd_front_addr,
   input  logic [AW-1:0]             rd_back_addr,
   output logic [DATA_WIDTH-1:0]     rd_front_data,
   output logic [DATA_WIDTH-1:0]     rd_back_data
);
   import rbdq_pkg::*;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] front_ff;
   logic [DATA_WIDTH-1:0] back_ff;

   // Write one entry, read front and back entries
   always_ff @(posedge clock) begin
      if (mem_ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_ctrl.rd_en) begin
         front_ff <= mem[rd_front_addr];
         back_ff  <= mem[rd_back_addr];
      end
   end

   assign rd_front_data = front_ff;
   assign rd_back_data  = back_ff;

endmodule

[sv/rbdq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbdq_ctrl: pointer and count sequencer
// Decodes the operation, moves the pointers, writes pushes and reads back.
// ----------------------------------------------------------------------------
module rbdq_ctrl #(
   parameter int DEPTH      = rbdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = rbdq_pkg::DATA_WIDTH_DEFAULT,
   parameter int AW         = $clog2(DEPTH),
   parameter int CW         = $clog2(DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rbdq_pkg::OPCODE_WIDTH-1:0]   req_opcode,
   input  logic [rbdq_pkg::WORD_WIDTH-1:0]     req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rbdq_pkg::mem_ctrl_type              mem_ctrl,
   output logic [AW-1:0]                       wr_addr,
   output logic [DATA_WIDTH-1:0]               wr_data,
   output logic [AW-1:0]                       rd_front_addr,
   output logic [AW-1:0]                       rd_back_addr,
   output logic [CW-1:0]                       count,
   output logic                                refused
);
   import rbdq_pkg::*;

   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   state_type     state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          refused_ff, refused_in;
   logic          accept;
   logic          full;
   logic          empty;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + AW'(1);
   endfunction

   function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] idx);
      return (idx == '0) ? LAST_IDX : idx - AW'(1);
   endfunction

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign full   = (count_ff == FULL_CNT);
   assign empty  = (count_ff == '0);

   // Decode the operation and work out the next pointers
   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      refused_in      = refused_ff;
      wr_addr         = tail_ff;
      mem_ctrl.wr_en  = 1'b0;
      // Read front and back once the pointers have settled
      mem_ctrl.rd_en  = (state_ff == ST_READ);
      if (accept) begin
         refused_in = 1'b0;
         case (req_opcode)
            OP_PUSH_FRONT: begin
               if (full) begin
                  refused_in = 1'b1;
               end else begin
                  head_in        = wrap_dec(head_ff);
                  wr_addr        = wrap_dec(head_ff);
                  mem_ctrl.wr_en = 1'b1;
                  count_in       = count_ff + CW'(1);
               end
            end
            OP_PUSH_BACK: begin
               if (full) begin
                  refused_in = 1'b1;
               end else begin
                  tail_in        = wrap_inc(tail_ff);
                  mem_ctrl.wr_en = 1'b1;
                  count_in       = count_ff + CW'(1);
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  refused_in = 1'b1;
               end else begin
                  head_in  = wrap_inc(head_ff);
                  count_in = count_ff - CW'(1);
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  refused_in = 1'b1;
               end else begin
                  tail_in  = wrap_dec(tail_ff);
                  count_in = count_ff - CW'(1);
               end
            end
            default: begin
               // plain read and unused codes leave the queue alone
            end
         endcase
      end
   end

   // Advance the sequencer: accept, read back, hold the response
   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = accept ? ST_READ : ST_IDLE;
         ST_READ: state_in = ST_RESP;
         ST_RESP: state_in = rsp_ready ? ST_IDLE : ST_RESP;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         refused_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         refused_ff <= refused_in;
      end
   end

   // Point the read ports at the front word and the back word
   assign rd_front_addr  = head_ff;
   assign rd_back_addr   = wrap_dec(tail_ff);
   assign wr_data        = DATA_WIDTH'(req_value);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign count     = count_ff;
   assign refused   = refused_ff;

endmodule

[sv/ring_buffer_deque.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_deque: double-ended queue in a circular store
//
//   Channel  Direction  Handshake             Payload
//   req_     in         req_valid/req_ready   opcode, value
//   rsp_     out        rsp_valid/rsp_ready   front/back word, occupancy, flags
//
// One operation at a time: the accept cycle moves the pointers and writes
// a pushed word, the next cycle (READ) reads front and back from the store,
// and the RESP state then presents the response.
// The store's single registered read stage calls for the READ state.
// A stalled response holds; no new request is taken until it transfers.
// Reset clears pointers, count and sequencer; the store needs no clearing.
// ----------------------------------------------------------------------------
module ring_buffer_deque #(
   parameter int DEPTH      = rbdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = rbdq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rbdq_pkg::OPCODE_WIDTH-1:0]   req_opcode,
   input  logic [rbdq_pkg::WORD_WIDTH-1:0]     req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rbdq_pkg::WORD_WIDTH-1:0]     rsp_front_word,
   output logic [rbdq_pkg::WORD_WIDTH-1:0]     rsp_back_word,
   output logic [rbdq_pkg::OCC_WIDTH-1:0]      rsp_occupancy,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   output logic                                rsp_refused
);
   import rbdq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   mem_ctrl_type          mem_ctrl;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [AW-1:0]         rd_front_addr;
   logic [AW-1:0]         rd_back_addr;
   logic [DATA_WIDTH-1:0] rd_front_data;
   logic [DATA_WIDTH-1:0] rd_back_data;
   logic [CW-1:0]         count;
   logic                  refused;

   rbdq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW),
      .CW         (CW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .mem_ctrl      (mem_ctrl),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_front_addr (rd_front_addr),
      .rd_back_addr  (rd_back_addr),
      .count         (count),
      .refused       (refused)
   );

   rbdq_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW)
   ) u_store (
      .clock         (clock),
      .mem_ctrl      (mem_ctrl),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_front_addr (rd_front_addr),
      .rd_back_addr  (rd_back_addr),
      .rd_front_data (rd_front_data),
      .rd_back_data  (rd_back_data)
   );

   // Format the response; an empty queue shows zero words
   assign rsp_is_empty   = (count == '0);
   assign rsp_is_full    = (count == CW'(DEPTH));
   assign rsp_front_word = rsp_is_empty ? '0 : WORD_WIDTH'(rd_front_data);
   assign rsp_back_word  = rsp_is_empty ? '0 : WORD_WIDTH'(rd_back_data);
   assign rsp_occupancy  = OCC_WIDTH'(count);
   assign rsp_refused    = refused;

endmodule

[sv/rbdq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbdq_checker: port-level checks for the ring buffer deque
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module rbdq_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [rbdq_pkg::WORD_WIDTH-1:0]     rsp_front_word,
   input  logic [rbdq_pkg::WORD_WIDTH-1:0]     rsp_back_word,
   input  logic [rbdq_pkg::OCC_WIDTH-1:0]      rsp_occupancy,
   input  logic                                rsp_is_empty,
   input  logic                                rsp_is_full,
   input  logic                                rsp_refused
);
   import rbdq_pkg::*;

   logic req_xfer;

   assign req_xfer   = req_valid && req_ready;

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_front_word)
         && $stable(rsp_back_word) && $stable(rsp_occupancy)
         && $stable(rsp_refused))
      else $error("response changed while stalled");

   // Only one operation in flight: no request transfer right after another
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("request taken while an operation is in flight");

   // Requests are not taken while a response waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while a response is pending");

   // An empty queue reports zero words, zero occupancy and not full
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_front_word == '0 && rsp_back_word == '0
         && rsp_occupancy == '0 && !rsp_is_full)
      else $error("empty queue with non-zero response fields");

endmodule

bind ring_buffer_deque rbdq_checker u_rbdq_checker (.*);
